// File: rtl/positional_array_table_engine_macros.svh
// Assertion macros for the positional array table engine checkers.
// Included by the checker file; needs clock and reset in scope.
`ifndef POSITIONAL_ARRAY_TABLE_ENGINE_MACROS_SVH
`define POSITIONAL_ARRAY_TABLE_ENGINE_MACROS_SVH

// same-cycle implication
`define PATE_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PATE_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/pate_pkg.sv
// Shared types and constants of the positional array table engine.
// No dependencies; imported by every module of the block except pate_ram.
`default_nettype none

package pate_pkg;

   localparam int OPCODE_W    = 3;
   localparam int POS_W       = 7;
   localparam int VALUE_W     = 32;
   localparam int STATUS_W    = 3;
   localparam int FPOS_W      = 6;
   localparam int COUNT_W     = 7;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 48;
   localparam int MAX_RESULTS = 64;

   typedef logic [OPCODE_W-1:0] opcode_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam opcode_type OP_INSERT = 3'd0;
   localparam opcode_type OP_DELETE = 3'd1;
   localparam opcode_type OP_SEARCH = 3'd2;
   localparam opcode_type OP_UPDATE = 3'd3;
   localparam opcode_type OP_DUMP   = 3'd4;

   localparam status_type ST_OK       = 3'd0;
   localparam status_type ST_FULL     = 3'd1;
   localparam status_type ST_EMPTY    = 3'd2;
   localparam status_type ST_BADPOS   = 3'd3;
   localparam status_type ST_NOTFOUND = 3'd4;

endpackage

`default_nettype wire

// File: rtl/pate_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; read data holds while no read is issued.
`default_nettype none

module pate_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire                      rd_en,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/pate_seq.sv
// Request sequencer: decodes requests, walks the entry RAM for shifts,
// searches and dumps, and holds the result register. Uses pate_pkg.
`default_nettype none

module pate_seq
   import pate_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  wire opcode_type          req_opcode,
   input  wire [POS_W-1:0]          req_position,
   input  wire [VALUE_W-1:0]        req_value,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output status_type               rsp_status,
   output logic [FPOS_W-1:0]        rsp_found_position,
   output logic [VALUE_W-1:0]       rsp_entry_value,
   output logic [COUNT_W-1:0]       rsp_entry_count,
   output logic                     rsp_last,
   output logic                     ram_wr_en,
   output logic [$clog2(DEPTH)-1:0] ram_wr_addr,
   output logic [VALUE_W-1:0]       ram_wr_data,
   output logic                     ram_rd_en,
   output logic [$clog2(DEPTH)-1:0] ram_rd_addr,
   input  wire [VALUE_W-1:0]        ram_rd_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_DECODE, S_SHIFT, S_SEARCH, S_DUMP, S_FINAL
   } state_type;

   state_type            state_ff, state_in;
   opcode_type           op_ff, op_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [VALUE_W-1:0]   key_ff, key_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic [AW-1:0]        end_ff, end_in;
   logic                 rd_act_ff, rd_act_in;
   logic                 pipe_vld_ff, pipe_vld_in;
   logic [AW-1:0]        pipe_idx_ff, pipe_idx_in;
   status_type           res_status_ff, res_status_in;
   logic [AW-1:0]        res_pos_ff, res_pos_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [FPOS_W-1:0]    rsp_pos_ff, rsp_pos_in;
   logic [VALUE_W-1:0]   rsp_value_ff, rsp_value_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 out_free;
   logic [CW-1:0]        count_m1;
   logic [AW-1:0]        last_idx;
   logic [AW-1:0]        dump_last;
   logic                 cnt_zero;
   logic                 cnt_full;
   logic                 pos_gt_cnt;
   logic                 pos_ge_cnt;
   logic                 shift_up;
   logic                 imm;
   status_type           imm_status;
   logic                 emit;
   status_type           emit_status;
   logic [AW-1:0]        emit_pos;
   logic [VALUE_W-1:0]   emit_value;
   logic                 emit_last;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign count_m1   = count_ff - CW'(1);
   assign last_idx   = AW'(count_m1);
   assign dump_last  = (32'(count_ff) > MAX_RESULTS) ? AW'(MAX_RESULTS - 1) : last_idx;
   assign cnt_zero   = (count_ff == '0);
   assign cnt_full   = (32'(count_ff) >= DEPTH);
   assign pos_gt_cnt = (32'(pos_ff) > 32'(count_ff));
   assign pos_ge_cnt = (32'(pos_ff) >= 32'(count_ff));
   assign shift_up   = (op_ff == OP_INSERT);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      pos_in        = pos_ff;
      key_in        = key_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      end_in        = end_ff;
      rd_act_in     = rd_act_ff;
      pipe_vld_in   = pipe_vld_ff;
      pipe_idx_in   = pipe_idx_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = pipe_idx_ff;
      ram_wr_data   = ram_rd_data;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = idx_ff;
      imm           = 1'b0;
      imm_status    = ST_OK;
      emit          = 1'b0;
      emit_status   = ST_OK;
      emit_pos      = '0;
      emit_value    = '0;
      emit_last     = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_opcode;
               pos_in   = req_position;
               key_in   = req_value;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            res_status_in = ST_OK;
            res_pos_in    = '0;
            pipe_vld_in   = 1'b0;
            unique case (op_ff)
               OP_INSERT: begin
                  if (cnt_full) begin
                     imm        = 1'b1;
                     imm_status = ST_FULL;
                  end else if (pos_gt_cnt) begin
                     imm        = 1'b1;
                     imm_status = ST_BADPOS;
                  end else if (32'(pos_ff) == 32'(count_ff)) begin
                     state_in = S_FINAL;
                  end else begin
                     idx_in    = last_idx;
                     end_in    = AW'(pos_ff);
                     rd_act_in = 1'b1;
                     state_in  = S_SHIFT;
                  end
               end
               OP_DELETE: begin
                  if (cnt_zero) begin
                     imm        = 1'b1;
                     imm_status = ST_EMPTY;
                  end else if (pos_ge_cnt) begin
                     imm        = 1'b1;
                     imm_status = ST_BADPOS;
                  end else if (32'(pos_ff) == 32'(count_m1)) begin
                     state_in = S_FINAL;
                  end else begin
                     idx_in    = AW'(pos_ff) + AW'(1);
                     end_in    = last_idx;
                     rd_act_in = 1'b1;
                     state_in  = S_SHIFT;
                  end
               end
               OP_SEARCH: begin
                  if (cnt_zero) begin
                     imm        = 1'b1;
                     imm_status = ST_NOTFOUND;
                  end else begin
                     idx_in    = '0;
                     end_in    = last_idx;
                     rd_act_in = 1'b1;
                     state_in  = S_SEARCH;
                  end
               end
               OP_UPDATE: begin
                  imm = 1'b1;
                  if (cnt_zero) begin
                     imm_status = ST_EMPTY;
                  end else if (pos_ge_cnt) begin
                     imm_status = ST_BADPOS;
                  end else begin
                     imm_status  = ST_OK;
                     ram_wr_en   = out_free;
                     ram_wr_addr = AW'(pos_ff);
                     ram_wr_data = key_ff;
                  end
               end
               OP_DUMP: begin
                  if (cnt_zero) begin
                     imm        = 1'b1;
                     imm_status = ST_EMPTY;
                  end else begin
                     idx_in    = '0;
                     end_in    = dump_last;
                     rd_act_in = 1'b1;
                     state_in  = S_DUMP;
                  end
               end
               default: begin
                  imm        = 1'b1;
                  imm_status = ST_BADPOS;
               end
            endcase
            if (imm && out_free) begin
               emit        = 1'b1;
               emit_status = imm_status;
               state_in    = S_IDLE;
            end
         end
         S_SHIFT: begin
            if (pipe_vld_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = shift_up ? pipe_idx_ff + AW'(1) : pipe_idx_ff - AW'(1);
            end
            pipe_vld_in = rd_act_ff;
            if (rd_act_ff) begin
               ram_rd_en   = 1'b1;
               pipe_idx_in = idx_ff;
               if (idx_ff == end_ff) begin
                  rd_act_in = 1'b0;
               end else begin
                  idx_in = shift_up ? idx_ff - AW'(1) : idx_ff + AW'(1);
               end
            end
            if (!rd_act_ff && !pipe_vld_ff) begin
               state_in = S_FINAL;
            end
         end
         S_SEARCH: begin
            if (pipe_vld_ff && ram_rd_data == key_ff) begin
               res_status_in = ST_OK;
               res_pos_in    = pipe_idx_ff;
               rd_act_in     = 1'b0;
               pipe_vld_in   = 1'b0;
               state_in      = S_FINAL;
            end else if (pipe_vld_ff && pipe_idx_ff == end_ff) begin
               res_status_in = ST_NOTFOUND;
               pipe_vld_in   = 1'b0;
               state_in      = S_FINAL;
            end else begin
               pipe_vld_in = rd_act_ff;
               if (rd_act_ff) begin
                  ram_rd_en   = 1'b1;
                  pipe_idx_in = idx_ff;
                  if (idx_ff == end_ff) begin
                     rd_act_in = 1'b0;
                  end else begin
                     idx_in = idx_ff + AW'(1);
                  end
               end
            end
         end
         S_DUMP: begin
            if (pipe_vld_ff && out_free) begin
               emit        = 1'b1;
               emit_pos    = pipe_idx_ff;
               emit_value  = ram_rd_data;
               emit_last   = (pipe_idx_ff == end_ff);
               pipe_vld_in = 1'b0;
               if (pipe_idx_ff == end_ff) begin
                  state_in = S_IDLE;
               end
            end
            if (rd_act_ff && (!pipe_vld_ff || out_free)) begin
               ram_rd_en   = 1'b1;
               pipe_vld_in = 1'b1;
               pipe_idx_in = idx_ff;
               if (idx_ff == end_ff) begin
                  rd_act_in = 1'b0;
               end else begin
                  idx_in = idx_ff + AW'(1);
               end
            end
         end
         S_FINAL: begin
            if (out_free) begin
               if (op_ff == OP_INSERT) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = AW'(pos_ff);
                  ram_wr_data = key_ff;
                  count_in    = count_ff + CW'(1);
               end else if (op_ff == OP_DELETE) begin
                  count_in = count_m1;
               end
               emit        = 1'b1;
               emit_status = res_status_ff;
               emit_pos    = res_pos_ff;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = emit_status;
         rsp_pos_in    = FPOS_W'(emit_pos);
         rsp_value_in  = emit_value;
         rsp_count_in  = COUNT_W'(count_in);
         rsp_last_in   = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rd_act_ff    <= 1'b0;
         pipe_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_act_ff    <= rd_act_in;
         pipe_vld_ff  <= pipe_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      pos_ff        <= pos_in;
      key_ff        <= key_in;
      idx_ff        <= idx_in;
      end_ff        <= end_in;
      pipe_idx_ff   <= pipe_idx_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found_position = rsp_pos_ff;
   assign rsp_entry_value    = rsp_value_ff;
   assign rsp_entry_count    = rsp_count_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

`default_nettype wire

// File: rtl/positional_array_table_engine.sv
// Positional array table engine: ordered table of signed 32-bit entries
// kept in one RAM. Top level; uses pate_pkg, pate_ram and pate_seq.
//
// Usage:
//  - req_* stream carries one request: opcode in tuser, position and value
//    in tdata. One request is worked at a time; req_tready is high only
//    while the sequencer is idle.
//  - rsp_* stream returns results: status in tuser, found position, entry
//    value and entry count in tdata, tlast on the final result of a request.
//    A dump returns one result per held entry (at most 64), others exactly one.
//  - Rejected requests and update answer straight from decode, insert at the
//    end from the final state; a shifting insert/delete or a search walks
//    the RAM first. A dump streams one entry per cycle while the receiver
//    does not stall. The single RAM read port sets the pace: every shift or
//    scan step is one RAM access.
//  - Reset clears the entry count and the result register; RAM contents
//    are left as they are and only entries below the count are ever read.
//  - A stalled receiver holds the result register; the sequencer waits
//    (a dump pauses mid-stream) and a new request is still taken while a
//    finished result waits.
`default_nettype none

module positional_array_table_engine
   import pate_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   input  wire [REQ_DATA_W-1:0]  req_tdata,  // position[6:0], value[38:7]
   input  wire [OPCODE_W-1:0]    req_tuser,  // opcode[2:0]
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // found_position[5:0], entry_value[37:6],
                                             // entry_count[44:38]
   output logic [STATUS_W-1:0]   rsp_tuser,  // status[2:0]
   output logic                  rsp_tlast
);

   localparam int AW = $clog2(DEPTH);
   localparam int RSP_USED_W = FPOS_W + VALUE_W + COUNT_W;

   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   logic [VALUE_W-1:0]  ram_wr_data;
   logic                ram_rd_en;
   logic [AW-1:0]       ram_rd_addr;
   logic [VALUE_W-1:0]  ram_rd_data;
   status_type          rsp_status;
   logic [FPOS_W-1:0]   rsp_found_position;
   logic [VALUE_W-1:0]  rsp_entry_value;
   logic [COUNT_W-1:0]  rsp_entry_count;

   pate_seq #(
      .DEPTH (DEPTH)
   ) u_seq (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_tvalid),
      .req_ready          (req_tready),
      .req_opcode         (req_tuser),
      .req_position       (req_tdata[POS_W-1:0]),
      .req_value          (req_tdata[POS_W+VALUE_W-1:POS_W]),
      .rsp_valid          (rsp_tvalid),
      .rsp_ready          (rsp_tready),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_entry_value    (rsp_entry_value),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_last           (rsp_tlast),
      .ram_wr_en          (ram_wr_en),
      .ram_wr_addr        (ram_wr_addr),
      .ram_wr_data        (ram_wr_data),
      .ram_rd_en          (ram_rd_en),
      .ram_rd_addr        (ram_rd_addr),
      .ram_rd_data        (ram_rd_data)
   );

   pate_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_tuser = rsp_status;
   assign rsp_tdata = {{(RSP_DATA_W - RSP_USED_W){1'b0}},
                       rsp_entry_count, rsp_entry_value, rsp_found_position};

endmodule

`default_nettype wire

// File: rtl/pate_checker.sv
// Port-level checks for the positional array table engine, bound to the top.
// Uses pate_pkg and positional_array_table_engine_macros.svh.
`default_nettype none

`include "positional_array_table_engine_macros.svh"

module pate_checker
   import pate_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input wire                  clock,
   input wire                  reset,
   input wire                  req_tvalid,
   input wire                  req_tready,
   input wire                  rsp_tvalid,
   input wire                  rsp_tready,
   input wire [RSP_DATA_W-1:0] rsp_tdata,
   input wire [STATUS_W-1:0]   rsp_tuser,
   input wire                  rsp_tlast
);

   `PATE_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast),
      "stalled result transaction changed")

   `PATE_ASSERT_IMP(a_err_single, rsp_tvalid && rsp_tuser != ST_OK,
      rsp_tlast && rsp_tdata[FPOS_W+VALUE_W-1:0] == '0, "error result not single and clean")

   `PATE_ASSERT_IMP(a_count_range, rsp_tvalid,
      32'(rsp_tdata[FPOS_W+VALUE_W+COUNT_W-1:FPOS_W+VALUE_W]) <= DEPTH,
      "entry count above depth")

   `PATE_ASSERT_NXT(a_one_at_a_time, req_tvalid && req_tready, !req_tready,
      "request taken while another is in work")

endmodule

bind positional_array_table_engine pate_checker #(.DEPTH(DEPTH)) u_pate_checker (.*);

`default_nettype wire

// File: test/tb_top.sv
// Self-checking bench for positional_array_table_engine: directed table rows, then
// random grow/shrink rounds, with results checked against an in-bench table predictor.
// Depends on pate_pkg and the RTL of positional_array_table_engine.
`timescale 1ns / 1ps

module tb_top;
   import pate_pkg::*;

   localparam int TABLE_DEPTH   = 64;
   localparam int RANDOM_ITEMS  = 300;
   localparam int HOLD_CYCLES   = 300;
   localparam int HOLD_AFTER    = 80;
   localparam int SETTLE_CYCLES = 80;

   // opcodes the block does not define
   localparam opcode_type OP_RSVD_LO  = 3'd5;
   localparam opcode_type OP_RSVD_MID = 3'd6;
   localparam opcode_type OP_RSVD_HI  = 3'd7;

   typedef struct packed {
      status_type  status;
      logic [5:0]  fpos;
      logic [31:0] value;
      logic [6:0]  count;
      logic        last;
   } table_reply_type;

   typedef struct packed {
      opcode_type  op;
      logic [6:0]  pos;
      logic [31:0] key;
      bit          typed;
      status_type  status;
      logic [6:0]  count;
   } request_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;  // position[6:0], value[38:7]
   logic [OPCODE_W-1:0]   req_tuser;  // opcode[2:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;  // found_position[5:0], entry_value[37:6],
                                      // entry_count[44:38]
   logic [STATUS_W-1:0]   rsp_tuser;  // status[2:0]
   logic                  rsp_tlast;

   logic [31:0]     held_values [TABLE_DEPTH];
   int              held_count;
   table_reply_type pending_replies [$];
   bit              record_replies;
   bit              steady_mode;
   int              mismatch_count;
   int              random_sent;

   request_row_type directed_rows [26] = '{
      '{OP_DUMP,     7'd0,   32'h0,         1'b1, ST_EMPTY,    7'd0},
      '{OP_SEARCH,   7'd0,   32'h0,         1'b1, ST_NOTFOUND, 7'd0},
      '{OP_DELETE,   7'd0,   32'h0,         1'b1, ST_EMPTY,    7'd0},
      '{OP_UPDATE,   7'd0,   32'h1234_5678, 1'b1, ST_EMPTY,    7'd0},
      '{OP_INSERT,   7'd1,   32'h1,         1'b1, ST_BADPOS,   7'd0},
      '{OP_RSVD_LO,  7'd0,   32'h0,         1'b1, ST_BADPOS,   7'd0},
      '{OP_RSVD_HI,  7'd127, 32'hffff_ffff, 1'b1, ST_BADPOS,   7'd0},
      '{OP_INSERT,   7'd0,   32'h8000_0000, 1'b1, ST_OK,       7'd1},
      '{OP_INSERT,   7'd1,   32'h7fff_ffff, 1'b1, ST_OK,       7'd2},
      '{OP_INSERT,   7'd0,   32'hffff_ffff, 1'b1, ST_OK,       7'd3},
      '{OP_INSERT,   7'd127, 32'h0,         1'b1, ST_BADPOS,   7'd3},
      '{OP_INSERT,   7'd4,   32'h0,         1'b1, ST_BADPOS,   7'd3},
      '{OP_INSERT,   7'd3,   32'h0,         1'b1, ST_OK,       7'd4},
      '{OP_SEARCH,   7'd0,   32'h7fff_ffff, 1'b0, ST_OK,       7'd0},
      '{OP_SEARCH,   7'd0,   32'h0001_2345, 1'b1, ST_NOTFOUND, 7'd4},
      '{OP_UPDATE,   7'd4,   32'h1,         1'b1, ST_BADPOS,   7'd4},
      '{OP_UPDATE,   7'd127, 32'h1,         1'b1, ST_BADPOS,   7'd4},
      '{OP_UPDATE,   7'd3,   32'h5555_5555, 1'b1, ST_OK,       7'd4},
      '{OP_INSERT,   7'd2,   32'hffff_ffff, 1'b1, ST_OK,       7'd5},
      '{OP_SEARCH,   7'd0,   32'hffff_ffff, 1'b0, ST_OK,       7'd0},
      '{OP_DUMP,     7'd0,   32'h0,         1'b0, ST_OK,       7'd0},
      '{OP_DELETE,   7'd0,   32'h0,         1'b1, ST_OK,       7'd4},
      '{OP_DELETE,   7'd3,   32'h0,         1'b1, ST_OK,       7'd3},
      '{OP_DELETE,   7'd64,  32'h0,         1'b1, ST_BADPOS,   7'd3},
      '{OP_RSVD_MID, 7'd42,  32'haaaa_aaaa, 1'b1, ST_BADPOS,   7'd3},
      '{OP_DUMP,     7'd0,   32'h0,         1'b0, ST_OK,       7'd0}
   };

   positional_array_table_engine #(
      .DEPTH(TABLE_DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("positional_array_table_engine: mismatch");
      $finish;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void push_reply(status_type st, logic [5:0] fp, logic [31:0] v,
                                      logic lst);
      table_reply_type r;
      r.status = st;
      r.fpos   = fp;
      r.value  = v;
      r.count  = held_count[6:0];
      r.last   = lst;
      if (record_replies) pending_replies.push_back(r);
   endfunction

   // table predictor: updates the held entries and queues the replies
   function automatic void apply_request(opcode_type op, logic [6:0] pos, logic [31:0] key);
      int p;
      int n;
      int hit;
      p   = pos;
      n   = held_count;
      hit = -1;
      case (op)
         OP_INSERT: begin
            if (n >= TABLE_DEPTH) begin
               push_reply(ST_FULL, '0, '0, 1'b1);
            end else if (p > n) begin
               push_reply(ST_BADPOS, '0, '0, 1'b1);
            end else begin
               for (int i = n; i > p; i--) held_values[i] = held_values[i-1];
               held_values[p] = key;
               held_count++;
               push_reply(ST_OK, '0, '0, 1'b1);
            end
         end
         OP_DELETE: begin
            if (n == 0) begin
               push_reply(ST_EMPTY, '0, '0, 1'b1);
            end else if (p >= n) begin
               push_reply(ST_BADPOS, '0, '0, 1'b1);
            end else begin
               for (int i = p; i + 1 < n; i++) held_values[i] = held_values[i+1];
               held_count--;
               push_reply(ST_OK, '0, '0, 1'b1);
            end
         end
         OP_SEARCH: begin
            for (int i = 0; i < n && hit < 0; i++)
               if (held_values[i] == key) hit = i;
            if (hit >= 0) push_reply(ST_OK, hit[5:0], '0, 1'b1);
            else push_reply(ST_NOTFOUND, '0, '0, 1'b1);
         end
         OP_UPDATE: begin
            if (n == 0) begin
               push_reply(ST_EMPTY, '0, '0, 1'b1);
            end else if (p >= n) begin
               push_reply(ST_BADPOS, '0, '0, 1'b1);
            end else begin
               held_values[p] = key;
               push_reply(ST_OK, '0, '0, 1'b1);
            end
         end
         OP_DUMP: begin
            if (n > MAX_RESULTS) n = MAX_RESULTS;
            if (n == 0) push_reply(ST_EMPTY, '0, '0, 1'b1);
            for (int i = 0; i < n; i++)
               push_reply(ST_OK, i[5:0], held_values[i], i == n - 1);
         end
         default: push_reply(ST_BADPOS, '0, '0, 1'b1);
      endcase
   endfunction

   function automatic void check_reply();
      table_reply_type got;
      table_reply_type want;
      got.status = rsp_tuser;
      got.fpos   = rsp_tdata[5:0];
      got.value  = rsp_tdata[37:6];
      got.count  = rsp_tdata[44:38];
      got.last   = rsp_tlast;
      if (pending_replies.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected transaction: status %0d pos %0d value %h count %0d last %0d",
                     got.status, got.fpos, got.value, got.count, got.last);
      end else begin
         want = pending_replies.pop_front();
         if (got.status !== want.status || got.fpos !== want.fpos ||
             got.value !== want.value || got.count !== want.count ||
             got.last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("exp: status %0d pos %0d value %h count %0d last %0d",
                        want.status, want.fpos, want.value, want.count, want.last);
               $display("act: status %0d pos %0d value %h count %0d last %0d",
                        got.status, got.fpos, got.value, got.count, got.last);
            end
         end
      end
   endfunction

   task automatic offer_request(opcode_type op, logic [6:0] pos, logic [31:0] key,
                                bit typed, status_type st, logic [6:0] cnt);
      int unsigned     gap;
      table_reply_type r;
      gap = steady_mode ? 0 : pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, key, pos};
      do @(posedge clock); while (!req_tready);
      record_replies = !typed;
      apply_request(op, pos, key);
      if (typed) begin
         r.status = st;
         r.fpos   = '0;
         r.value  = '0;
         r.count  = cnt;
         r.last   = 1'b1;
         pending_replies.push_back(r);
      end
   endtask

   task automatic wait_for_replies();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_replies.size() != 0);
   endtask

   task automatic offer_random(bit growing);
      int unsigned r;
      opcode_type  op;
      logic [6:0]  pos;
      logic [31:0] key;
      r = $urandom_range(0, 99);
      if (growing)
         op = r < 55 ? OP_INSERT : r < 63 ? OP_DELETE : r < 78 ? OP_SEARCH :
              r < 90 ? OP_UPDATE : r < 96 ? OP_DUMP : opcode_type'($urandom_range(5, 7));
      else
         op = r < 50 ? OP_DELETE : r < 60 ? OP_INSERT : r < 75 ? OP_SEARCH :
              r < 87 ? OP_UPDATE : r < 94 ? OP_DUMP : opcode_type'($urandom_range(5, 7));
      r = $urandom_range(0, 99);
      if (r < 12) pos = 7'($urandom_range(0, 127));
      else if (op == OP_INSERT) pos = 7'($urandom_range(0, held_count));
      else if (held_count > 0) pos = 7'($urandom_range(0, held_count - 1));
      else pos = '0;
      r = $urandom_range(0, 99);
      if (r < 12) begin
         case ($urandom_range(0, 3))
            0: key = 32'h0000_0000;
            1: key = 32'hffff_ffff;
            2: key = 32'h8000_0000;
            default: key = 32'h7fff_ffff;
         endcase
      end else if (r < 35 && held_count > 0) begin
         key = held_values[$urandom_range(0, held_count - 1)];
      end else begin
         key = $urandom;
      end
      offer_request(op, pos, key, 1'b0, ST_OK, '0);
      random_sent++;
      if (random_sent % 40 == 0) steady_mode = ($urandom_range(0, 3) == 0);
   endtask

   initial begin : drive_requests
      int target;
      int round;
      reset          <= 1'b1;
      req_tvalid     <= 1'b0;
      req_tdata      <= '0;
      req_tuser      <= OP_INSERT;
      held_count     = 0;
      mismatch_count = 0;
      random_sent    = 0;
      steady_mode    = 1'b0;
      record_replies = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         offer_request(directed_rows[i].op, directed_rows[i].pos, directed_rows[i].key,
                       directed_rows[i].typed, directed_rows[i].status,
                       directed_rows[i].count);
      wait_for_replies();

      // rounds: fill toward a target (every third round, the first included, to full), then drain to empty
      round = 0;
      while (random_sent < RANDOM_ITEMS) begin
         target = (round % 3 == 0) ? TABLE_DEPTH : $urandom_range(3, 40);
         while (held_count < target && random_sent < RANDOM_ITEMS) offer_random(1'b1);
         if (held_count == TABLE_DEPTH) begin
            offer_request(OP_INSERT, 7'd64, 32'h0bad_cafe, 1'b1, ST_FULL, 7'd64);
            offer_request(OP_DUMP, 7'd0, 32'h0, 1'b0, ST_OK, '0);
            random_sent += 2;
         end
         if (round == 1) wait_for_replies();
         while (held_count > 0 && random_sent < RANDOM_ITEMS) offer_random(1'b0);
         round++;
      end
      req_tvalid <= 1'b0;

      while (pending_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_replies.size() == 0)
         $display("positional_array_table_engine: match");
      else
         $display("positional_array_table_engine: mismatch");
      $finish;
   end

   initial begin : drain_responses
      int unsigned stall_left;
      int unsigned gap;
      int          accepted;
      bit          held_off;
      stall_left = 0;
      accepted   = 0;
      held_off   = 1'b0;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            check_reply();
            accepted++;
         end
         // long back-pressure so the request side fills up and stalls
         if (!held_off && accepted >= HOLD_AFTER) begin
            held_off = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (steady_mode) begin
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            gap = pick_gap();
            if (gap == 0) begin
               rsp_tready <= 1'b1;
            end else begin
               rsp_tready <= 1'b0;
               stall_left = gap - 1;
            end
         end
      end
   end

endmodule
